@@ rtl/frame_peak_rms_meter_top_defines.svh @@
// Assertion macros used by the frame meter top level.
`ifndef FRAME_PEAK_RMS_METER_TOP_DEFINES_SVH
`define FRAME_PEAK_RMS_METER_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk_i and disabled in reset.
`define FPRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i and disabled in reset.
`define FPRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fprm_pkg.sv @@
// Package with the constants, types and state encodings of the frame meter.
package fprm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_FRAME   = 1024;
  localparam int SUM_W       = 41;
  localparam int CNT_W       = $clog2(MAX_FRAME + 1);
  localparam int SQ_W        = 2 * SAMPLE_BITS - 1;
  localparam int RAD_W       = 2 * SAMPLE_BITS;
  localparam int ROOT_W      = SAMPLE_BITS;
  localparam int DIV_REM_W   = CNT_W + 1;
  localparam int SQRT_REM_W  = ROOT_W + 4;
  localparam int REM_W       = (DIV_REM_W > SQRT_REM_W) ? DIV_REM_W : SQRT_REM_W;
  localparam int STEP_W      = $clog2(SUM_W);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_CALC,
    ST_OUT
  } fprm_state_e;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_DIV,
    ENG_SQRT,
    ENG_DONE
  } fprm_eng_e;

  typedef struct packed {
    logic load;
    logic acc;
    logic close;
  } fprm_acc_ctrl_t;

  typedef struct packed {
    sample_t            max_value;
    sample_t            min_value;
    logic [SUM_W-1:0]   square_sum;
    logic [CNT_W-1:0]   sample_count;
    logic               overflow;
  } fprm_snap_t;

endpackage

@@ rtl/fprm_accum.sv @@
// Frame accumulators: running extremes, registered square, saturating sum and count.
module fprm_accum
  import fprm_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fprm_acc_ctrl_t ctrl_i,
  input  sample_t        sample_i,
  output fprm_snap_t     snap_o
);

  sample_t                  max_q, min_q;
  logic [SUM_W-1:0]         sum_q, sum_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     ovf_q, ovf_d;
  logic [SQ_W-1:0]          sq_q;
  logic signed [SAMPLE_BITS:0] sample_ext, mag_ext;
  logic [SAMPLE_BITS-1:0]   mag;
  logic [2*SAMPLE_BITS-1:0] product;
  logic [SUM_W:0]           sum_ext;
  logic                     full;

  assign sample_ext = (SAMPLE_BITS + 1)'(sample_i);
  assign mag_ext    = sample_ext[SAMPLE_BITS] ? -sample_ext : sample_ext;
  assign mag        = mag_ext[SAMPLE_BITS-1:0];
  assign product    = mag * mag;

  always_comb begin
    full    = (count_q >= CNT_W'(MAX_FRAME));
    sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(sq_q);
    sum_d   = sum_q;
    count_d = count_q;
    ovf_d   = ovf_q | full;
    if (!full) begin
      sum_d   = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      min_q   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (ctrl_i.load) begin
      if (sample_i > max_q) begin
        max_q <= sample_i;
      end
      if (sample_i < min_q) begin
        min_q <= sample_i;
      end
    end else if (ctrl_i.acc) begin
      if (ctrl_i.close) begin
        max_q   <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        min_q   <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        sum_q   <= '0;
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else begin
        sum_q   <= sum_d;
        count_q <= count_d;
        ovf_q   <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sq_q <= product[SQ_W-1:0];
    end
  end

  assign snap_o.max_value    = max_q;
  assign snap_o.min_value    = min_q;
  assign snap_o.square_sum   = sum_d;
  assign snap_o.sample_count = count_d;
  assign snap_o.overflow     = ovf_d;

endmodule

@@ rtl/fprm_divsqrt.sv @@
// Iterative engine that divides the square sum by the count and takes the floor square root.
module fprm_divsqrt
  import fprm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  fprm_eng_e         state_q, state_d;
  logic [SUM_W-1:0]  work_q, work_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  divisor_q, divisor_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [REM_W-1:0]  rem_sh, sub_b;
  logic [REM_W:0]    diff;
  logic              ge;

  // One shared subtractor serves both the division and the root steps.
  always_comb begin
    if (state_q == ENG_SQRT) begin
      rem_sh = {rem_q[REM_W-3:0], work_q[RAD_W-1 -: 2]};
      sub_b  = REM_W'({root_q, 2'b01});
    end else begin
      rem_sh = {rem_q[REM_W-2:0], work_q[SUM_W-1]};
      sub_b  = REM_W'(divisor_q);
    end
    diff = {1'b0, rem_sh} - {1'b0, sub_b};
    ge   = ~diff[REM_W];
  end

  always_comb begin
    state_d   = state_q;
    work_d    = work_q;
    rem_d     = rem_q;
    root_d    = root_q;
    divisor_d = divisor_q;
    step_d    = step_q;
    case (state_q)
      ENG_IDLE: begin
        if (start_i) begin
          work_d    = dividend_i;
          rem_d     = '0;
          divisor_d = (divisor_i == '0) ? CNT_W'(1) : divisor_i;
          step_d    = STEP_W'(SUM_W - 1);
          state_d   = ENG_DIV;
        end
      end
      ENG_DIV: begin
        work_d = {work_q[SUM_W-2:0], ge};
        rem_d  = ge ? diff[REM_W-1:0] : rem_sh;
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          rem_d   = '0;
          root_d  = '0;
          step_d  = STEP_W'(ROOT_W - 1);
          state_d = ENG_SQRT;
        end
      end
      ENG_SQRT: begin
        work_d = {work_q[SUM_W-3:0], 2'b00};
        rem_d  = ge ? diff[REM_W-1:0] : rem_sh;
        root_d = {root_q[ROOT_W-2:0], ge};
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = ENG_DONE;
        end
      end
      ENG_DONE: begin
        state_d = ENG_IDLE;
      end
      default: begin
        state_d = ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ENG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    rem_q     <= rem_d;
    root_q    <= root_d;
    divisor_q <= divisor_d;
    step_q    <= step_d;
  end

  assign busy_o = (state_q != ENG_IDLE);
  assign done_o = (state_q == ENG_DONE);
  assign root_o = root_q;

endmodule

@@ rtl/frame_peak_rms_meter_top.sv @@
// Top level of the frame peak and RMS meter with its sequencer and output register.
// The slave stream carries one signed sample per transaction in s_axis_tdata, with
// s_axis_tlast marking the last sample of a frame. Every sample updates the running
// maximum, minimum, square sum and count. After an ordinary sample, s_axis_tready drops
// for the accumulate state, the cycle in which the registered square is added to the sum.
// The last sample of a frame starts the shared divide and root engine: 41 restoring
// division steps and 16 root steps on one subtractor. The accumulate state, the engine
// steps and its done state lead to the output state, which loads the frame result once
// the output register is free; s_axis_tready stays low until it has been loaded. The
// result carries max, min, peak magnitude, peak-to-peak and RMS in m_axis_tdata and the
// overflow flag in m_axis_tuser. A held result does not block the next frame: only
// loading a new result waits for m_axis_tready to free the output register. Frames
// longer than 1024 samples saturate the count and sum and set the overflow flag.
// Reset empties the output register and clears all accumulators.
`include "frame_peak_rms_meter_top_defines.svh"

module frame_peak_rms_meter_top
  import fprm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // [15:0] max_value, [31:16] min_value,
                                     // [47:32] peak_magnitude, [63:48] peak_to_peak,
                                     // [79:64] rms_value
  output logic        m_axis_tuser   // [0] overflow
);

  fprm_state_e       state_q, state_d;
  fprm_acc_ctrl_t    acc_ctrl;
  fprm_snap_t        snap;
  logic              last_q;
  logic              eng_start, eng_busy, eng_done;
  logic [ROOT_W-1:0] eng_root;
  logic              out_load, out_valid_q;
  logic [79:0]       out_data_q;
  logic              out_ovf_q;
  sample_t           res_max_q, res_min_q;
  logic              res_ovf_q;
  logic signed [SAMPLE_BITS:0] max_ext, min_ext, amax, amin, p2p;
  logic [SAMPLE_BITS-1:0]      peak;

  fprm_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (acc_ctrl),
    .sample_i (sample_t'(s_axis_tdata[SAMPLE_BITS-1:0])),
    .snap_o   (snap)
  );

  fprm_divsqrt u_divsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (eng_start),
    .dividend_i (snap.square_sum),
    .divisor_i  (snap.sample_count),
    .busy_o     (eng_busy),
    .done_o     (eng_done),
    .root_o     (eng_root)
  );

  always_comb begin
    state_d        = state_q;
    s_axis_tready  = 1'b0;
    acc_ctrl.load  = 1'b0;
    acc_ctrl.acc   = 1'b0;
    acc_ctrl.close = 1'b0;
    eng_start      = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          acc_ctrl.load = 1'b1;
          state_d       = ST_ACC;
        end
      end
      ST_ACC: begin
        acc_ctrl.acc   = 1'b1;
        acc_ctrl.close = last_q;
        if (last_q) begin
          eng_start = 1'b1;
          state_d   = ST_CALC;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CALC: begin
        if (eng_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign max_ext = (SAMPLE_BITS + 1)'(res_max_q);
  assign min_ext = (SAMPLE_BITS + 1)'(res_min_q);
  assign amax    = max_ext[SAMPLE_BITS] ? -max_ext : max_ext;
  assign amin    = min_ext[SAMPLE_BITS] ? -min_ext : min_ext;
  assign peak    = (amax > amin) ? amax[SAMPLE_BITS-1:0] : amin[SAMPLE_BITS-1:0];
  assign p2p     = max_ext - min_ext;

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      last_q <= s_axis_tlast;
    end
    if (acc_ctrl.close) begin
      res_max_q <= snap.max_value;
      res_min_q <= snap.min_value;
      res_ovf_q <= snap.overflow;
    end
    if (out_load) begin
      out_data_q <= {eng_root, p2p[SAMPLE_BITS-1:0], peak, res_min_q, res_max_q};
      out_ovf_q  <= res_ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

  `FPRM_ASSERT_NEXT(a_short_sample, (state_q == ST_ACC) && !last_q, s_axis_tready,
                    "ordinary sample did not return to ready after two cycles")
  `FPRM_ASSERT_NOW(a_busy_not_ready, eng_busy, !s_axis_tready,
                   "input ready while the divide and root engine runs")
  `FPRM_ASSERT_NOW(a_load_free, out_load, !m_axis_tvalid || m_axis_tready,
                   "result loaded over an untaken result")
  `FPRM_ASSERT_NOW(a_count_bound, acc_ctrl.acc,
                   snap.sample_count <= CNT_W'(MAX_FRAME),
                   "frame sample count exceeds its limit")

endmodule
